### rtl/core/stt_pkg.sv
// stt_pkg: shared types, codes and byte constants of the source text tokenizer
// no dependencies; imported by every module of the block
package stt_pkg;

	localparam int unsigned TOKEN_BYTES_DEFAULT = 24;
	localparam int unsigned LEN_W = 5;
	localparam int unsigned TEXT_W = 192;
	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_PTR_W = 2;
	localparam int unsigned OUTQ_CNT_W = 3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [3:0] {
		KIND_IDENT    = 4'd0,
		KIND_KEYWORD  = 4'd1,
		KIND_OPERATOR = 4'd2,
		KIND_CONST    = 4'd3,
		KIND_SPECIAL  = 4'd4,
		KIND_INTEGER  = 4'd5,
		KIND_FLOAT    = 4'd6,
		KIND_STRING   = 4'd7,
		KIND_OVERFLOW = 4'd8
	} token_kind_t;

	typedef enum logic [1:0] {
		QS_NO     = 2'd0,
		QS_BODY   = 2'd1,
		QS_ESC    = 2'd2,
		QS_CLOSED = 2'd3
	} quote_scan_t;

	typedef enum logic [1:0] {
		NS_NO   = 2'd0,
		NS_INT  = 2'd1,
		NS_DOT  = 2'd2,
		NS_FRAC = 2'd3
	} number_scan_t;

	typedef struct packed {
		token_kind_t       kind;
		logic [LEN_W-1:0]  length;
		logic [TEXT_W-1:0] text;
		logic              last;
	} stt_result_t;

endpackage

### rtl/core/stt_lexer.sv
// stt_lexer: pending token store, comment/overflow flags and token classifier
// depends on stt_pkg; produces up to two results per accepted byte
module stt_lexer import stt_pkg::*; #(
	parameter int unsigned MAX_TOKEN_BYTES = TOKEN_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  ch,
	input  logic        end_of_source,
	output stt_result_t res_a,
	output stt_result_t res_b,
	output logic [1:0]  n_res
);

	localparam int unsigned IDX_W = $clog2(MAX_TOKEN_BYTES);

	logic [7:0]       token_bytes_q [MAX_TOKEN_BYTES];
	logic [LEN_W-1:0] count_q, count_d;
	logic             comment_q, comment_d;
	logic             ovf_q, ovf_d;
	quote_scan_t      qs_q, qs_d;
	number_scan_t     ns_q, ns_d;
	logic             wr_en;

	logic [TEXT_W-1:0] pend_text;
	token_kind_t       pend_kind;
	stt_result_t       pend_res, char_res, ovf_res;
	logic              is_space, is_op, is_digit, is_kw, const_word;

	always_comb begin
		pend_text = '0;
		for (int i = 0; i < MAX_TOKEN_BYTES; i++) begin
			if (LEN_W'(i) < count_q) begin
				pend_text[i*8 +: 8] = token_bytes_q[i];
			end
		end
	end

	assign is_kw =
		(count_q == LEN_W'(3) && token_bytes_q[0] == "i" && token_bytes_q[1] == "n"
			&& token_bytes_q[2] == "t") ||
		(count_q == LEN_W'(5) && token_bytes_q[0] == "f" && token_bytes_q[1] == "l"
			&& token_bytes_q[2] == "o" && token_bytes_q[3] == "a"
			&& token_bytes_q[4] == "t") ||
		(count_q == LEN_W'(3) && token_bytes_q[0] == "s" && token_bytes_q[1] == "t"
			&& token_bytes_q[2] == "r") ||
		(count_q == LEN_W'(4) && token_bytes_q[0] == "b" && token_bytes_q[1] == "o"
			&& token_bytes_q[2] == "o" && token_bytes_q[3] == "l");

	assign const_word = count_q == LEN_W'(5) && token_bytes_q[0] == "c"
		&& token_bytes_q[1] == "o" && token_bytes_q[2] == "n"
		&& token_bytes_q[3] == "s" && token_bytes_q[4] == "t";

	always_comb begin
		if (is_kw) begin
			pend_kind = KIND_KEYWORD;
		end else if (const_word) begin
			pend_kind = KIND_CONST;
		end else if (qs_q == QS_CLOSED) begin
			pend_kind = KIND_STRING;
		end else if (ns_q == NS_INT) begin
			pend_kind = KIND_INTEGER;
		end else if (ns_q == NS_FRAC) begin
			pend_kind = KIND_FLOAT;
		end else begin
			pend_kind = KIND_IDENT;
		end
	end

	assign is_space = ch inside {CH_NUL, CH_SPACE, [CH_TAB:CH_CR]};
	assign is_op    = ch inside {CH_PLUS, CH_EQUAL, CH_STAR, CH_SLASH, CH_MINUS};
	assign is_digit = ch inside {[CH_ZERO:CH_NINE]};

	always_comb begin
		pend_res = '{kind: pend_kind, length: count_q, text: pend_text, last: 1'b1};
		char_res = '{kind: (ch == CH_COLON) ? KIND_SPECIAL : KIND_OPERATOR,
			length: LEN_W'(1), text: {{(TEXT_W-8){1'b0}}, ch}, last: 1'b1};
		ovf_res = '{kind: KIND_OVERFLOW, length: '0, text: '0, last: 1'b1};
	end

	always_comb begin
		res_a     = pend_res;
		res_b     = char_res;
		n_res     = 2'd0;
		count_d   = count_q;
		comment_d = comment_q;
		ovf_d     = ovf_q;
		qs_d      = qs_q;
		ns_d      = ns_q;
		wr_en     = 1'b0;
		if (accept) begin
			if (end_of_source) begin
				if (!ovf_q && count_q != '0) begin
					n_res = 2'd1;
				end
				count_d   = '0;
				qs_d      = QS_NO;
				ns_d      = NS_NO;
				comment_d = 1'b0;
				ovf_d     = 1'b0;
			end else if (ovf_q) begin
				ovf_d = 1'b1;
			end else if (comment_q) begin
				if (ch == CH_NL) begin
					comment_d = 1'b0;
				end
			end else if (ch == CH_HASH) begin
				if (count_q != '0) begin
					n_res = 2'd1;
				end
				comment_d = 1'b1;
				count_d   = '0;
				qs_d      = QS_NO;
				ns_d      = NS_NO;
			end else if (is_space) begin
				if (count_q != '0) begin
					n_res = 2'd1;
				end
				count_d = '0;
				qs_d    = QS_NO;
				ns_d    = NS_NO;
			end else if (is_op || ch == CH_COLON) begin
				if (count_q != '0) begin
					res_a.last = 1'b0;
					n_res      = 2'd2;
				end else begin
					res_a = char_res;
					n_res = 2'd1;
				end
				count_d = '0;
				qs_d    = QS_NO;
				ns_d    = NS_NO;
			end else if (count_q >= LEN_W'(MAX_TOKEN_BYTES)) begin
				res_a   = ovf_res;
				n_res   = 2'd1;
				count_d = '0;
				qs_d    = QS_NO;
				ns_d    = NS_NO;
				ovf_d   = 1'b1;
			end else begin
				wr_en   = 1'b1;
				count_d = count_q + LEN_W'(1);
				if (count_q == '0) begin
					qs_d = (ch == CH_QUOTE) ? QS_BODY : QS_NO;
					ns_d = is_digit ? NS_INT : NS_NO;
				end else begin
					case (qs_q)
						QS_BODY: begin
							qs_d = (ch == CH_QUOTE) ? QS_CLOSED
								: (ch == CH_BSLASH) ? QS_ESC : QS_BODY;
						end
						QS_ESC: begin
							qs_d = QS_BODY;
						end
						default: begin
							qs_d = QS_NO;
						end
					endcase
					case (ns_q)
						NS_INT: begin
							ns_d = is_digit ? NS_INT : (ch == CH_DOT) ? NS_DOT : NS_NO;
						end
						NS_DOT, NS_FRAC: begin
							ns_d = is_digit ? NS_FRAC : NS_NO;
						end
						default: begin
							ns_d = NS_NO;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			comment_q <= 1'b0;
			ovf_q     <= 1'b0;
			qs_q      <= QS_NO;
			ns_q      <= NS_NO;
		end else begin
			count_q   <= count_d;
			comment_q <= comment_d;
			ovf_q     <= ovf_d;
			qs_q      <= qs_d;
			ns_q      <= ns_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			token_bytes_q[count_q[IDX_W-1:0]] <= ch;
		end
	end

endmodule

### rtl/core/stt_outq.sv
// stt_outq: four-entry result queue, takes up to two results per cycle
// depends on stt_pkg; head entry drives the output channel from registers
module stt_outq import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  stt_result_t res_a,
	input  stt_result_t res_b,
	input  logic [1:0]  n_res,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output stt_result_t head
);

	stt_result_t           entries_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wptr_q, rptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign head      = entries_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + OUTQ_PTR_W'(n_res);
			rptr_q  <= rptr_q + OUTQ_PTR_W'(pop);
			count_q <= count_q + OUTQ_CNT_W'(n_res) - OUTQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			entries_q[wptr_q] <= res_a;
		end
		if (n_res == 2'd2) begin
			entries_q[wptr_q + OUTQ_PTR_W'(1)] <= res_b;
		end
	end

endmodule

### rtl/core/source_text_tokenizer.sv
// source_text_tokenizer: top level, byte stream in, classified tokens out
// depends on stt_pkg, stt_lexer, stt_outq
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | ch, end_of_source
//  out     | out_valid / out_ready| token_kind, token_length, text_low/mid/high,
//          |                      | last_of_run
//
// one byte is taken per cycle while room is high; its results are written
// to the result queue in the same cycle and can be taken from the next cycle on
// a byte may give two results, so input is taken while at most two queue
// entries are held; the queue's four entries set this figure
// a stall on the out side only holds input once more than two results wait
// arst_n clears the lexer state and the queue; no clearing pass
module source_text_tokenizer import stt_pkg::*; #(
	parameter int unsigned MAX_TOKEN_BYTES = TOKEN_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [4:0]  token_length,
	output logic [63:0] text_low,
	output logic [63:0] text_mid,
	output logic [63:0] text_high,
	output logic        last_of_run
);

	stt_result_t res_a, res_b, head;
	logic [1:0]  n_res;
	logic        room;
	logic        accept;

	assign in_ready = room;
	assign accept   = in_valid && room;

	stt_lexer #(
		.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
	) u_lexer (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.ch            (ch),
		.end_of_source (end_of_source),
		.res_a         (res_a),
		.res_b         (res_b),
		.n_res         (n_res)
	);

	stt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_a     (res_a),
		.res_b     (res_b),
		.n_res     (n_res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign token_length = head.length;
	assign text_low     = head.text[63:0];
	assign text_mid     = head.text[127:64];
	assign text_high    = head.text[191:128];
	assign last_of_run  = head.last;

endmodule

### rtl/core/stt_checker.sv
// stt_checker: port level checks of the tokenizer's result channel
// depends on stt_pkg; bound to source_text_tokenizer below
module stt_checker import stt_pkg::*; #(
	parameter int unsigned MAX_TOKEN_BYTES = TOKEN_BYTES_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic [4:0]  token_length,
	input logic [63:0] text_low,
	input logic [63:0] text_mid,
	input logic [63:0] text_high,
	input logic        last_of_run
);

	// stalled transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(token_kind) && $stable(token_length)
			&& $stable(text_low) && $stable(text_mid) && $stable(text_high)
			&& $stable(last_of_run))
		else $error("result changed while stalled");

	a_overflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_OVERFLOW |-> token_length == '0
			&& text_low == '0 && text_mid == '0 && text_high == '0 && last_of_run)
		else $error("overflow result carries text");

	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_OPERATOR || token_kind == KIND_SPECIAL)
			|-> token_length == 5'd1 && last_of_run && text_low[63:8] == '0)
		else $error("operator result malformed");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_OVERFLOW |-> token_length != '0
			&& token_length <= LEN_W'(MAX_TOKEN_BYTES))
		else $error("token length out of range");

endmodule

bind source_text_tokenizer stt_checker #(
	.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)
) u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.token_kind   (token_kind),
	.token_length (token_length),
	.text_low     (text_low),
	.text_mid     (text_mid),
	.text_high    (text_high),
	.last_of_run  (last_of_run)
);
